// File: rtl/core/mppr_pkg.sv
// ----------------------------------------------------------------------------
// mppr_pkg
// Shared types and constants of the predictive pixel reconstruction block.
// ----------------------------------------------------------------------------
package mppr_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W     = COL_W + 1;
  localparam int CFG_W     = 12;
  localparam int SAMP_W    = 8;
  localparam int RES_W     = 9;
  localparam int NUM_CH    = 3;
  localparam int PIX_W     = SAMP_W * NUM_CH;
  localparam int RES_ALL_W = RES_W * NUM_CH;
  localparam int IN_DATA_W = ((RES_ALL_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_LEFT  = 2'd1,
    MODE_ABOVE = 2'd2,
    MODE_MED   = 2'd3
  } pred_mode_t;

endpackage

// File: rtl/core/med_predictive_pixel_reconstruct.sv
// ----------------------------------------------------------------------------
// med_predictive_pixel_reconstruct
// Rebuilds 8-bit BGR pixels from median-edge-detector prediction residuals.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, back to back, unless the output stalls. The
// line store read is registered with stage 1 at the accepting edge, the
// three channel lanes work from it combinationally, and their result lands
// in the output register as stage 1 advances, raising out_tvalid. A stalled
// output holds two pixels (stage 1 and the output register) before in_tready
// drops. The line store is single-ported per direction (one read, one write
// a cycle), and a read of the column written in the same cycle is bypassed.
// The line store needs no clearing after reset; the first row of a frame
// never uses it. image_width must be written only while the block is idle.
// ----------------------------------------------------------------------------
module med_predictive_pixel_reconstruct (
  input  logic                           clk,
  input  logic                           rst_n,
  // cfg_data: image_width
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mppr_pkg::CFG_W-1:0]     cfg_data,
  // in_tdata: resid_b [8:0], resid_g [17:9], resid_r [26:18], zero pad
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mppr_pkg::IN_DATA_W-1:0] in_tdata,
  // in_tuser: frame_start
  input  logic                           in_tuser,
  // out_tdata: pix_b [7:0], pix_g [15:8], pix_r [23:16]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mppr_pkg::PIX_W-1:0]     out_tdata
);
  import mppr_pkg::*;

  logic [CFG_W-1:0]     width_cfg_r;
  logic [CNT_W-1:0]     width_eff;

  logic [COL_W-1:0]     col_r;
  logic [COL_W-1:0]     col_nxt;
  logic                 first_r;
  logic                 first_nxt;
  logic [COL_W-1:0]     col_sel;
  logic                 first_sel;
  logic [CNT_W-1:0]     col_inc;
  pred_mode_t           mode_sel;

  logic                 s1_valid_r;
  logic [COL_W-1:0]     s1_col_r;
  pred_mode_t           s1_mode_r;
  logic [RES_ALL_W-1:0] s1_resid_r;
  logic                 s1_byp_r;
  logic [PIX_W-1:0]     s1_byp_data_r;

  logic                 out_valid_r;
  logic [PIX_W-1:0]     out_data_r;

  logic [PIX_W-1:0]     left_r;
  logic [PIX_W-1:0]     upper_r;

  logic                 in_accept;
  logic                 advance;
  logic [PIX_W-1:0]     ram_rdata;
  logic [PIX_W-1:0]     above;
  logic [PIX_W-1:0]     pix;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r <= CFG_W'(MAX_WIDTH);
    end else if (cfg_valid && cfg_ready) begin
      width_cfg_r <= cfg_data;
    end
  end

  always_comb begin
    if (width_cfg_r == '0) begin
      width_eff = CNT_W'(1);
    end else if (32'(width_cfg_r) > 32'(MAX_WIDTH)) begin
      width_eff = CNT_W'(MAX_WIDTH);
    end else begin
      width_eff = CNT_W'(width_cfg_r);
    end
  end

  // handshake
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  // position tracking at acceptance
  always_comb begin
    col_sel   = in_tuser ? '0 : col_r;
    first_sel = in_tuser ? 1'b1 : first_r;
    col_inc   = {1'b0, col_sel} + CNT_W'(1);
    if (col_inc >= width_eff) begin
      col_nxt   = '0;
      first_nxt = 1'b0;
    end else begin
      col_nxt   = col_inc[COL_W-1:0];
      first_nxt = first_sel;
    end
    if (first_sel && col_sel == '0) begin
      mode_sel = MODE_FIRST;
    end else if (first_sel) begin
      mode_sel = MODE_LEFT;
    end else if (col_sel == '0) begin
      mode_sel = MODE_ABOVE;
    end else begin
      mode_sel = MODE_MED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      first_r    <= 1'b1;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        col_r      <= col_nxt;
        first_r    <= first_nxt;
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col_r      <= col_sel;
      s1_mode_r     <= mode_sel;
      s1_resid_r    <= in_tdata[RES_ALL_W-1:0];
      s1_byp_r      <= advance && (s1_col_r == col_sel);
      s1_byp_data_r <= pix;
    end
  end

  // line store
  mppr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (advance),
    .waddr (s1_col_r),
    .wdata (pix),
    .re    (in_accept),
    .raddr (col_sel),
    .rdata (ram_rdata)
  );

  assign above = s1_byp_r ? s1_byp_data_r : ram_rdata;

  // channel lanes
  for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
    mppr_lane u_lane (
      .mode    (s1_mode_r),
      .left_s  (left_r[k*SAMP_W +: SAMP_W]),
      .above_s (above[k*SAMP_W +: SAMP_W]),
      .upper_s (upper_r[k*SAMP_W +: SAMP_W]),
      .resid   (s1_resid_r[k*RES_W +: RES_W]),
      .pix     (pix[k*SAMP_W +: SAMP_W])
    );
  end

  // merge and hold result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      left_r      <= '0;
      upper_r     <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        left_r      <= pix;
        upper_r     <= above;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= pix;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_stall_holds_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |=> s1_valid_r)
    else $error("stage 1 word dropped while output stalled");

  a_advance_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced word missing from output register");

  a_frame_start_mode : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser) |=> (s1_mode_r == MODE_FIRST && s1_col_r == '0))
    else $error("frame start not taken as first pixel");

  a_col_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (32'(col_r) < 32'(MAX_WIDTH)))
    else $error("column position out of range");

endmodule

// File: rtl/core/mppr_ram.sv
// ----------------------------------------------------------------------------
// mppr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/mppr_lane.sv
// ----------------------------------------------------------------------------
// mppr_lane
// One color channel: forms the prediction and adds the residual modulo 256.
// ----------------------------------------------------------------------------
module mppr_lane (
  input  mppr_pkg::pred_mode_t         mode,
  input  logic [mppr_pkg::SAMP_W-1:0]  left_s,
  input  logic [mppr_pkg::SAMP_W-1:0]  above_s,
  input  logic [mppr_pkg::SAMP_W-1:0]  upper_s,
  input  logic signed [mppr_pkg::RES_W-1:0] resid,
  output logic [mppr_pkg::SAMP_W-1:0]  pix
);
  import mppr_pkg::*;

  logic [SAMP_W-1:0] hi;
  logic [SAMP_W-1:0] lo;
  logic [SAMP_W-1:0] med;
  logic [SAMP_W-1:0] pred;

  always_comb begin
    hi = (left_s > above_s) ? left_s : above_s;
    lo = (left_s > above_s) ? above_s : left_s;
    if (upper_s >= hi) begin
      med = lo;
    end else if (upper_s <= lo) begin
      med = hi;
    end else begin
      med = left_s + above_s - upper_s;
    end
    case (mode)
      MODE_FIRST: pred = '0;
      MODE_LEFT:  pred = left_s;
      MODE_ABOVE: pred = above_s;
      MODE_MED:   pred = med;
      default:    pred = '0;
    endcase
    pix = pred + resid[SAMP_W-1:0];
  end

endmodule

// File: test/tb_med_predictive_pixel_reconstruct.sv
// ----------------------------------------------------------------------------
// tb_med_predictive_pixel_reconstruct
// Self-checking bench for the MED pixel reconstruction block. A table of
// directed pixels and width writes runs first, then random frames under
// several stall mixes. Each output word is checked against a value given
// in the table or against an in-bench pixel predictor that keeps its own
// copy of the line store and the neighbor samples.
// ----------------------------------------------------------------------------
module tb_med_predictive_pixel_reconstruct;
  timeunit 1ns;
  timeprecision 1ps;

  import mppr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 160;

  typedef struct {
    bit                 is_cfg;
    logic [CFG_W-1:0]   width;
    logic               fs;
    logic [RES_W-1:0]   rb;
    logic [RES_W-1:0]   rg;
    logic [RES_W-1:0]   rr;
    bit                 known;
    logic [PIX_W-1:0]   pix;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [PIX_W-1:0]     out_tdata;

  // predictor state
  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  bit               line_set [MAX_WIDTH];
  logic [PIX_W-1:0] left_px;
  logic [PIX_W-1:0] ul_px;
  int unsigned      col_pos;
  bit               first_row;
  logic [CFG_W-1:0] width_reg;

  logic [PIX_W-1:0] pix_expect_q [$];
  logic [PIX_W-1:0] pix_got_q [$];
  dir_row_t         dir_tbl [$];

  int send_gap_pct;
  int recv_stall_pct;
  int hold_left;
  int err_cnt;
  int cycle_cnt;

  med_predictive_pixel_reconstruct uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [SAMP_W-1:0] med_edge(logic [SAMP_W-1:0] a, logic [SAMP_W-1:0] b,
                                                 logic [SAMP_W-1:0] c);
    logic [SAMP_W-1:0] hi;
    logic [SAMP_W-1:0] lo;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    if (c >= hi) return lo;
    if (c <= lo) return hi;
    return a + b - c;
  endfunction

  function automatic logic [PIX_W-1:0] reconstruct_pixel(logic fs, logic [RES_W-1:0] rb,
                                                         logic [RES_W-1:0] rg,
                                                         logic [RES_W-1:0] rr);
    int unsigned                 eff_w;
    int unsigned                 col;
    int                          k;
    logic [PIX_W-1:0]            above;
    logic [PIX_W-1:0]            pix;
    logic [NUM_CH-1:0][RES_W-1:0] res;
    logic [SAMP_W-1:0]           pred;
    pred_mode_t                  mode;
    eff_w = (width_reg == '0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    if (fs) begin
      col_pos   = 0;
      first_row = 1'b1;
    end
    col   = col_pos;
    above = line_mem[col];
    if (first_row) mode = (col == 0) ? MODE_FIRST : MODE_LEFT;
    else           mode = (col == 0) ? MODE_ABOVE : MODE_MED;
    res = {rr, rg, rb};
    for (k = 0; k < NUM_CH; k++) begin
      case (mode)
        MODE_FIRST: pred = '0;
        MODE_LEFT:  pred = left_px[SAMP_W*k +: SAMP_W];
        MODE_ABOVE: pred = above[SAMP_W*k +: SAMP_W];
        default:    pred = med_edge(left_px[SAMP_W*k +: SAMP_W], above[SAMP_W*k +: SAMP_W],
                                    ul_px[SAMP_W*k +: SAMP_W]);
      endcase
      pix[SAMP_W*k +: SAMP_W] = pred + res[k][SAMP_W-1:0];
    end
    ul_px         = above;
    line_mem[col] = pix;
    line_set[col] = 1'b1;
    left_px       = pix;
    if (col + 1 >= eff_w) begin
      col_pos   = 0;
      first_row = 1'b0;
    end else begin
      col_pos = col + 1;
    end
    return pix;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_W-1:0] w);
    dir_row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.width  = w;
    return r;
  endfunction

  function automatic dir_row_t pix_row(logic fs, logic [RES_W-1:0] rb, logic [RES_W-1:0] rg,
                                       logic [RES_W-1:0] rr, bit known = 1'b0,
                                       logic [PIX_W-1:0] pix = '0);
    dir_row_t r;
    r       = '{default: '0};
    r.fs    = fs;
    r.rb    = rb;
    r.rg    = rg;
    r.rr    = rr;
    r.known = known;
    r.pix   = pix;
    return r;
  endfunction

  function automatic logic [RES_W-1:0] rand_resid();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       return 9'h0ff;
        1:       return 9'h101;
        2:       return 9'h100;
        default: return 9'h000;
      endcase
    end
    return RES_W'($urandom);
  endfunction

  task automatic report(input string msg);
    if (err_cnt < 10) $display("%s", msg);
    err_cnt++;
  endtask

  task automatic send_pixel(input logic fs, input logic [RES_W-1:0] rb,
                            input logic [RES_W-1:0] rg, input logic [RES_W-1:0] rr,
                            input bit known, input logic [PIX_W-1:0] pix);
    logic             fs_eff;
    logic [PIX_W-1:0] pred_pix;
    fs_eff = fs;
    // restart the frame rather than read a line store entry never written
    if (!fs_eff && !first_row && !line_set[col_pos]) fs_eff = 1'b1;
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fs_eff;
    in_tdata  <= IN_DATA_W'({rr, rg, rb});
    do @(posedge clk); while (!in_tready);
    pred_pix = reconstruct_pixel(fs_eff, rb, rg, rr);
    pix_expect_q.push_back(known ? pix : pred_pix);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pix_expect_q.size() != 0 || pix_got_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_reg = w;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) pix_got_q.push_back(out_tdata);
  end

  always @(negedge clk) begin : cmp_blk
    logic [PIX_W-1:0] got;
    logic [PIX_W-1:0] want;
    int               k;
    string            ch_name;
    while (pix_got_q.size() != 0) begin
      got = pix_got_q.pop_front();
      if (pix_expect_q.size() == 0) begin
        report($sformatf("unexpected word %06h", got));
      end else begin
        want = pix_expect_q.pop_front();
        for (k = 0; k < NUM_CH; k++) begin
          ch_name = (k == 0) ? "b" : (k == 1) ? "g" : "r";
          if (got[SAMP_W*k +: SAMP_W] !== want[SAMP_W*k +: SAMP_W])
            report($sformatf("pix_%s mismatch: expected %02h, got %02h", ch_name,
                             want[SAMP_W*k +: SAMP_W], got[SAMP_W*k +: SAMP_W]));
        end
      end
    end
  end

  initial begin
    int i;
    int ph;
    int sent;
    int len;
    int j;
    int unsigned w_now;
    bit paused;

    rst_n          <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    in_tuser       <= 1'b0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    err_cnt        = 0;
    cycle_cnt      = 0;
    for (i = 0; i < MAX_WIDTH; i++) begin
      line_mem[i] = '0;
      line_set[i] = 1'b0;
    end
    left_px   = '0;
    ul_px     = '0;
    col_pos   = 0;
    first_row = 1'b1;
    width_reg = CFG_W'(MAX_WIDTH);

    dir_tbl.push_back(pix_row(1'b0, 9'h0ff, 9'h0ff, 9'h100, 1'b1, 24'h00ffff));
    dir_tbl.push_back(pix_row(1'b0, 9'h001, 9'h001, 9'h1ff, 1'b1, 24'hff0000));
    dir_tbl.push_back(cfg_row(12'd0));
    dir_tbl.push_back(pix_row(1'b0, 9'h001, 9'h002, 9'h003, 1'b1, 24'h020201));
    dir_tbl.push_back(pix_row(1'b0, 9'h005, 9'h005, 9'h005, 1'b1, 24'h050404));
    dir_tbl.push_back(cfg_row(12'd3));
    dir_tbl.push_back(pix_row(1'b1, 9'h080, 9'h17f, 9'h0aa, 1'b1, 24'haa7f80));
    dir_tbl.push_back(pix_row(1'b0, 9'h0ff, 9'h001, 9'h17f));
    dir_tbl.push_back(pix_row(1'b0, 9'h010, 9'h1f0, 9'h055));
    dir_tbl.push_back(pix_row(1'b0, 9'h100, 9'h000, 9'h0ff));
    dir_tbl.push_back(pix_row(1'b0, 9'h033, 9'h1cc, 9'h0f0));
    dir_tbl.push_back(pix_row(1'b0, 9'h1ff, 9'h101, 9'h0fe));
    dir_tbl.push_back(pix_row(1'b0, 9'h07f, 9'h180, 9'h001));
    dir_tbl.push_back(pix_row(1'b0, 9'h000, 9'h000, 9'h000));
    dir_tbl.push_back(pix_row(1'b0, 9'h0c0, 9'h040, 9'h120));
    dir_tbl.push_back(cfg_row(12'd2));
    dir_tbl.push_back(pix_row(1'b0, 9'h002, 9'h1fe, 9'h040));
    dir_tbl.push_back(pix_row(1'b0, 9'h011, 9'h022, 9'h033));
    dir_tbl.push_back(cfg_row(12'hfff));
    dir_tbl.push_back(pix_row(1'b1, 9'h000, 9'h000, 9'h000, 1'b1, 24'h000000));
    dir_tbl.push_back(pix_row(1'b1, 9'h0ff, 9'h0ff, 9'h0ff, 1'b1, 24'hffffff));
    dir_tbl.push_back(pix_row(1'b0, 9'h101, 9'h101, 9'h101, 1'b1, 24'h000000));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) write_width(dir_tbl[i].width);
      else send_pixel(dir_tbl[i].fs, dir_tbl[i].rb, dir_tbl[i].rg, dir_tbl[i].rr,
                      dir_tbl[i].known, dir_tbl[i].pix);
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       w_now = $urandom_range(2, 9);
        1:       w_now = $urandom_range(10, 40);
        2:       w_now = 1;
        default: w_now = $urandom_range(2, 16);
      endcase
      write_width(CFG_W'(w_now));
      case (ph)
        0: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
          hold_left      = 400;
        end
        1: begin
          send_gap_pct   = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct   = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_gap_pct   = 35;
          recv_stall_pct = 35;
        end
      endcase
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        if (ph == 2 && !paused && sent >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 85) begin
          len = $urandom_range(1, 4) * w_now;
          if ($urandom_range(3) == 0) len += $urandom_range(0, w_now);
          for (j = 0; j < len && sent < PHASE_ITEMS; j++) begin
            send_pixel(j == 0, rand_resid(), rand_resid(), rand_resid(), 1'b0, '0);
            sent++;
          end
        end else begin
          len = $urandom_range(1, 6);
          for (j = 0; j < len && sent < PHASE_ITEMS; j++) begin
            send_pixel($urandom_range(3) == 0, rand_resid(), rand_resid(), rand_resid(),
                       1'b0, '0);
            sent++;
          end
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    hold_left = 1000;
    repeat (3) @(posedge clk);
    if (err_cnt == 0 && pix_expect_q.size() == 0 && pix_got_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
